FILE: rtl/core/tcb_pkg.sv
// Package for the windowed trace capture buffer.
// Holds the command, reply and state codes, the bus widths and the FNV-1a step.
// No dependencies.
package tcb_pkg;

  localparam int CMD_W        = 3;
  localparam int KIND_W       = 3;
  localparam int IN_DATA_W    = 136;
  localparam int OUT_DATA_W   = 224;
  localparam int COUNT_OUT_W  = 12;
  localparam int INDEX_OUT_W  = 11;
  localparam int TIME_W       = 32;
  localparam int PAYLOAD_W    = 64;
  localparam int HASH_W       = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 32'd2166136261;
  localparam logic [31:0]       WINDOW_RESET = 32'd10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 3'd0,
    CMD_ARM    = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_DUMP   = 3'd3,
    CMD_NEXT   = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    REP_ARMED  = 3'd0,
    REP_BUSY   = 3'd1,
    REP_STATUS = 3'd2,
    REP_DUMP   = 3'd3,
    REP_END    = 3'd4,
    REP_RECORD = 3'd5,
    REP_ERROR  = 3'd6
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HASH,
    ST_DONE
  } state_t;

  // (h ^ b) * 0x01000193 as shifts and adds
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

FILE: rtl/core/windowed_trace_capture_buffer.sv
// Top level of the windowed trace capture buffer: command decode, capture
// window, record store and readout sequencing.
// Depends on tcb_pkg, tcb_ram and tcb_hash.
//
//  Channel  Ports                 Content
//  input    in_tvalid/tready      tuser: cmd; tdata: now_ms, stamp_ms, payload, contact
//  result   out_tvalid/tready     tuser: reply_kind; tdata: flags, count, times, record
//  config   cfg_wr_en/wr_data     window_ms
//
// Record, arm, status, dump and a next that returns no record are done in the idle state.
// A next that returns a record goes through ST_READ (one RAM read), ST_HASH (the
// byte-serial hash of the record) and ST_DONE, where the result register is loaded.
// Reset clears flags, count, cursor and arm time and loads the default window;
// the store is not cleared.
// Input is taken only while idle and the result register is free or draining.
module windowed_trace_capture_buffer #(
  parameter int CAPACITY     = 2048,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] now_ms, [63:32] stamp_ms, [127:64] record_payload, [128] contact
  input  logic [tcb_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] cmd
  input  logic [tcb_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] capturing_flag, [1] touching_flag, [13:2] record_count, [14] full_flag,
  // [46:15] start_time, [78:47] time_now, [89:79] read_index,
  // [121:90] read_stamp_ms, [185:122] read_payload, [217:186] read_hash
  output logic [tcb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] reply_kind
  output logic [tcb_pkg::KIND_W-1:0]        out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [31:0]                       cfg_wr_data
);
  import tcb_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int REC_W = TIME_W + PAYLOAD_BITS;

  state_t state_r, state_nxt;

  logic [31:0]             window_r;
  logic [TIME_W-1:0]       arm_time_r, arm_time_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           cursor_r, cursor_nxt;
  logic                    cap_r, cap_nxt;
  logic                    touch_r, touch_nxt;
  logic                    full_r, full_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [TIME_W-1:0]       rec_ts_r, rec_ts_nxt;
  logic [PAYLOAD_BITS-1:0] rec_pl_r, rec_pl_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [REC_W-1:0]        ram_rdata;
  logic                    hash_start;
  logic                    hash_busy;
  logic [HASH_W-1:0]       hash_val;

  logic [TIME_W-1:0]       in_now, in_sample;
  logic [PAYLOAD_BITS-1:0] in_pl;
  logic                    in_contact;
  logic                    accept, out_free, cap_live, samp_ok, busy, load_out;
  reply_t                  kind;
  logic [TIME_W-1:0]       sel_now;
  logic [AW-1:0]           sel_idx;
  logic [TIME_W-1:0]       sel_ts;
  logic [PAYLOAD_BITS-1:0] sel_pl;
  logic [HASH_W-1:0]       sel_hash;

  assign in_now     = in_tdata[31:0];
  assign in_sample  = in_tdata[63:32];
  assign in_pl      = in_tdata[64 +: PAYLOAD_BITS];
  assign in_contact = in_tdata[128];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign cap_live  = cap_r && ((in_now - arm_time_r) < window_r);
  assign samp_ok   = (in_sample - arm_time_r) < window_r;
  assign busy      = cap_live || touch_r;

  always_comb begin
    state_nxt     = state_r;
    arm_time_nxt  = arm_time_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    cap_nxt       = cap_r;
    touch_nxt     = touch_r;
    full_nxt      = full_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    rec_ts_nxt    = rec_ts_r;
    rec_pl_nxt    = rec_pl_r;
    ram_we        = 1'b0;
    hash_start    = 1'b0;
    load_out      = 1'b0;
    kind          = REP_ERROR;
    sel_now       = in_now;
    sel_idx       = '0;
    sel_ts        = '0;
    sel_pl        = '0;
    sel_hash      = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cap_nxt = cap_live;
          if (cmd_t'(in_tuser) == CMD_RECORD) begin
            touch_nxt = in_contact;
            if (cap_live && samp_ok && (count_r < CW'(CAPACITY))) begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              if (count_r == CW'(CAPACITY - 1)) begin
                full_nxt = 1'b1;
                cap_nxt  = 1'b0;
              end
            end
          end else begin
            load_out = 1'b1;
            unique case (cmd_t'(in_tuser))
              CMD_ARM: begin
                if (busy) begin
                  kind = REP_BUSY;
                end else begin
                  count_nxt    = '0;
                  cursor_nxt   = '0;
                  full_nxt     = 1'b0;
                  arm_time_nxt = in_now;
                  cap_nxt      = 1'b1;
                  kind         = REP_ARMED;
                end
              end
              CMD_STATUS: kind = REP_STATUS;
              CMD_DUMP: begin
                if (busy) begin
                  kind = REP_BUSY;
                end else begin
                  cursor_nxt = '0;
                  kind       = REP_DUMP;
                end
              end
              CMD_NEXT: begin
                if (busy) begin
                  kind = REP_BUSY;
                end else if (cursor_r >= count_r || cursor_r >= CW'(CAPACITY)) begin
                  kind = REP_END;
                end else begin
                  load_out   = 1'b0;
                  idx_nxt    = cursor_r[AW-1:0];
                  cursor_nxt = cursor_r + CW'(1);
                  now_nxt    = in_now;
                  state_nxt  = ST_READ;
                end
              end
              default: kind = REP_ERROR;
            endcase
          end
        end
      end
      ST_READ: begin
        rec_ts_nxt = ram_rdata[TIME_W-1:0];
        rec_pl_nxt = ram_rdata[REC_W-1:TIME_W];
        hash_start = 1'b1;
        state_nxt  = ST_HASH;
      end
      ST_HASH: begin
        if (!hash_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          kind      = REP_RECORD;
          sel_now   = now_r;
          sel_idx   = idx_r;
          sel_ts    = rec_ts_r;
          sel_pl    = rec_pl_r;
          sel_hash  = hash_val;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = kind;
      out_data_nxt  = {6'd0, sel_hash, PAYLOAD_W'(sel_pl), sel_ts,
                       INDEX_OUT_W'(sel_idx), sel_now, arm_time_nxt, full_nxt,
                       COUNT_OUT_W'(count_nxt), touch_nxt, cap_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      arm_time_r  <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      cap_r       <= 1'b0;
      touch_r     <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      arm_time_r  <= arm_time_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      cap_r       <= cap_nxt;
      touch_r     <= touch_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    idx_r      <= idx_nxt;
    rec_ts_r   <= rec_ts_nxt;
    rec_pl_r   <= rec_pl_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

  tcb_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_pl, in_sample}),
    .raddr (cursor_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tcb_hash #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .ts    (ram_rdata[TIME_W-1:0]),
    .pl    (ram_rdata[REC_W-1:TIME_W]),
    .busy  (hash_busy),
    .hash  (hash_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

FILE: rtl/core/tcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcb_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tcb_hash.sv
// Byte-serial FNV-1a hash over one stored record (timestamp, then payload,
// both little-endian). One byte leaves the shift register per cycle.
// Depends on tcb_pkg.
module tcb_hash #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tcb_pkg::TIME_W-1:0]      ts,
  input  logic [PAYLOAD_BITS-1:0]         pl,
  output logic                            busy,
  output logic [tcb_pkg::HASH_W-1:0]      hash
);
  import tcb_pkg::*;

  localparam int PB_BYTES = (PAYLOAD_BITS + 7) / 8;
  localparam int NBYTES   = 4 + PB_BYTES;
  localparam int SR_W     = NBYTES * 8;
  localparam int CNT_W    = $clog2(NBYTES + 1);

  logic [SR_W-1:0]   sr_r, sr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;

  always_comb begin
    sr_nxt   = sr_r;
    cnt_nxt  = cnt_r;
    hash_nxt = hash_r;
    if (start) begin
      sr_nxt   = {(PB_BYTES * 8)'(pl), ts};
      cnt_nxt  = CNT_W'(NBYTES);
      hash_nxt = FNV_BASIS;
    end else if (cnt_r != '0) begin
      hash_nxt = fnv_step(hash_r, sr_r[7:0]);
      sr_nxt   = sr_r >> 8;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r   <= sr_nxt;
    hash_r <= hash_nxt;
  end

  assign busy = (cnt_r != '0);
  assign hash = hash_r;

endmodule

FILE: test/tb.sv
// Testbench for windowed_trace_capture_buffer: drives command transfers and checks each reply
// against a cycle-free model of the capture store, window expiry and FNV-1a readout.
// Depends on tcb_pkg and the windowed_trace_capture_buffer RTL.
`timescale 1ns / 1ps

module tb;
  import tcb_pkg::*;

  localparam int          CAP         = 2048;
  localparam int          STALL_LIMIT = 5000;
  localparam logic [31:0] FNV_MULT    = 32'd16777619;
  localparam logic [2:0]  CMD_RSVD5   = 3'd5;
  localparam logic [2:0]  CMD_RSVD6   = 3'd6;
  localparam logic [2:0]  CMD_RSVD7   = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now;
    logic [31:0] sample;
    logic [63:0] payload;
    logic        contact;
  } trace_item_t;

  typedef struct packed {
    reply_t      kind;
    logic        cap;
    logic        touch;
    logic [11:0] count;
    logic        full;
    logic [31:0] start;
    logic [31:0] now_echo;
    logic [10:0] idx;
    logic [31:0] ts;
    logic [63:0] pl;
    logic [31:0] hash;
  } trace_reply_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [CMD_W-1:0]      in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [31:0]           cfg_wr_data = '0;

  trace_item_t  item_q[$];
  trace_reply_t reply_q[$];
  logic         in_taken    = 1'b0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           errors      = 0;
  int           stall       = 0;

  // model state
  logic [31:0] win_ms     = WINDOW_RESET;
  logic [31:0] arm_ms     = '0;
  logic [11:0] rec_count  = '0;
  logic [11:0] rd_ptr     = '0;
  logic        capture_on = 1'b0;
  logic        touch_on   = 1'b0;
  logic        full_on    = 1'b0;
  logic [31:0] ts_mem[CAP];
  logic [63:0] pl_mem[CAP];

  windowed_trace_capture_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] trace_hash(input logic [31:0] ts, input logic [63:0] pl);
    logic [31:0] h;
    int i;
    h = FNV_BASIS;
    for (i = 0; i < 4; i++) h = (h ^ {24'd0, ts[8*i +: 8]}) * FNV_MULT;
    for (i = 0; i < 8; i++) h = (h ^ {24'd0, pl[8*i +: 8]}) * FNV_MULT;
    return h;
  endfunction

  task automatic trace_predict(input trace_item_t it);
    trace_reply_t r;
    logic busy;
    r = '0;
    if (capture_on && (it.now - arm_ms) >= win_ms) capture_on = 1'b0;
    busy = capture_on || touch_on;
    r.kind = REP_ERROR;
    case (it.cmd)
      CMD_RECORD: begin
        touch_on = it.contact;
        if (capture_on && (it.sample - arm_ms) < win_ms && rec_count < CAP) begin
          ts_mem[rec_count[10:0]] = it.sample;
          pl_mem[rec_count[10:0]] = it.payload;
          rec_count = rec_count + 1'b1;
          if (rec_count >= CAP) begin
            full_on = 1'b1;
            capture_on = 1'b0;
          end
        end
      end
      CMD_ARM: begin
        if (busy) begin
          r.kind = REP_BUSY;
        end else begin
          rec_count = '0;
          rd_ptr = '0;
          full_on = 1'b0;
          arm_ms = it.now;
          capture_on = 1'b1;
          r.kind = REP_ARMED;
        end
      end
      CMD_STATUS: r.kind = REP_STATUS;
      CMD_DUMP: begin
        if (busy) begin
          r.kind = REP_BUSY;
        end else begin
          rd_ptr = '0;
          r.kind = REP_DUMP;
        end
      end
      CMD_NEXT: begin
        if (busy) begin
          r.kind = REP_BUSY;
        end else if (rd_ptr >= rec_count) begin
          r.kind = REP_END;
        end else begin
          r.idx = rd_ptr[10:0];
          r.ts = ts_mem[rd_ptr[10:0]];
          r.pl = pl_mem[rd_ptr[10:0]];
          r.hash = trace_hash(r.ts, r.pl);
          rd_ptr = rd_ptr + 1'b1;
          r.kind = REP_RECORD;
        end
      end
      default: r.kind = REP_ERROR;
    endcase
    if (it.cmd != CMD_RECORD) begin
      r.cap = capture_on;
      r.touch = touch_on;
      r.count = rec_count;
      r.full = full_on;
      r.start = arm_ms;
      r.now_echo = it.now;
      reply_q.push_back(r);
    end
  endtask

  task automatic cmp(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // driver
  always @(negedge clk) begin : drive
    trace_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
      if (!in_tvalid || in_taken) begin
        if (item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = item_q.pop_front();
          in_tdata <= {7'd0, nxt.contact, nxt.payload, nxt.sample, nxt.now};
          in_tuser <= nxt.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : observe
    trace_item_t  got;
    trace_reply_t want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        got.cmd = in_tuser;
        got.now = in_tdata[31:0];
        got.sample = in_tdata[63:32];
        got.payload = in_tdata[127:64];
        got.contact = in_tdata[128];
        trace_predict(got);
      end
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t unexpected reply: expected none, actual kind %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = reply_q.pop_front();
          cmp("reply_kind", want.kind, out_tuser);
          cmp("capturing_flag", want.cap, out_tdata[0]);
          cmp("touching_flag", want.touch, out_tdata[1]);
          cmp("record_count", want.count, out_tdata[13:2]);
          cmp("full_flag", want.full, out_tdata[14]);
          cmp("start_time", want.start, out_tdata[46:15]);
          cmp("time_now", want.now_echo, out_tdata[78:47]);
          cmp("read_index", want.idx, out_tdata[89:79]);
          cmp("read_stamp_ms", want.ts, out_tdata[121:90]);
          cmp("read_payload", want.pl, out_tdata[185:122]);
          cmp("read_hash", want.hash, out_tdata[217:186]);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [2:0] c, input logic [31:0] n, input logic [31:0] s,
                           input logic [63:0] p, input logic ct);
    trace_item_t it;
    it.cmd = c;
    it.now = n;
    it.sample = s;
    it.payload = p;
    it.contact = ct;
    item_q.push_back(it);
  endtask

  // a time at least one window past base, at most span beyond that
  function automatic logic [31:0] past_window(input logic [31:0] base, input logic [31:0] span);
    logic [32:0] room;
    logic [32:0] k;
    room = 33'h1_0000_0000 - {1'b0, win_ms};
    if ({1'b0, span} + 33'd1 < room) room = {1'b0, span} + 33'd1;
    k = {1'b0, $urandom} % room;
    return base + win_ms + k[31:0];
  endfunction

  task automatic drain();
    while (item_q.size() != 0 || in_tvalid || reply_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic set_window(input logic [31:0] w);
    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_ms = w;
    @(posedge clk);
    #1;
  endtask

  task automatic directed();
    push_item(CMD_STATUS, 32'd0, 32'd0, 64'd0, 1'b0);
    push_item(CMD_NEXT, 32'd1, 32'd0, 64'd0, 1'b0);
    push_item(CMD_DUMP, 32'd2, 32'd0, 64'd0, 1'b0);
    push_item(CMD_RSVD5, 32'd2, 32'hFFFF_FFFF, '1, 1'b1);
    push_item(CMD_RSVD6, 32'd2, 32'd0, 64'd0, 1'b0);
    push_item(CMD_RSVD7, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1);
    push_item(CMD_RECORD, 32'd3, 32'd3, 64'd0, 1'b1);
    push_item(CMD_ARM, 32'd4, 32'd0, 64'd0, 1'b0);
    push_item(CMD_DUMP, 32'd4, 32'd0, 64'd0, 1'b0);
    push_item(CMD_NEXT, 32'd4, 32'd0, 64'd0, 1'b0);
    push_item(CMD_RECORD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '1, 1'b0);
    push_item(CMD_ARM, 32'hFFFF_FFF0, 32'd0, 64'd0, 1'b0);
    push_item(CMD_RECORD, 32'hFFFF_FFF8, 32'hFFFF_FFFF, '1, 1'b0);
    push_item(CMD_RECORD, 32'hFFFF_FFFC, 32'd0, 64'd0, 1'b0);
    push_item(CMD_RECORD, 32'd1, 32'h0000_26FF, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_item(CMD_RECORD, 32'd2, 32'h0000_2700, 64'hFEDC_BA98_7654_3210, 1'b0);
    push_item(CMD_RECORD, 32'd3, 32'hFFFF_FFEF, '1, 1'b0);
    push_item(CMD_STATUS, 32'd5, 32'd0, 64'd0, 1'b0);
    push_item(CMD_NEXT, 32'd5, 32'd0, 64'd0, 1'b0);
    push_item(CMD_ARM, 32'd6, 32'd0, 64'd0, 1'b0);
    // window end lands exactly on now
    push_item(CMD_RECORD, 32'h0000_2700, 32'h0000_0010, '1, 1'b0);
    push_item(CMD_DUMP, 32'h0000_2701, 32'd0, 64'd0, 1'b0);
    repeat (4) push_item(CMD_NEXT, 32'h0000_2702, 32'd0, 64'd0, 1'b0);
    push_item(CMD_STATUS, 32'h0000_2703, 32'd0, 64'd0, 1'b0);
  endtask

  task automatic run_session(input int n_rec, input bit near_wrap);
    logic [31:0] t0;
    logic [31:0] tn;
    logic [31:0] smp;
    logic [31:0] stepmax;
    int i;
    t0 = past_window(arm_ms, $urandom_range(1) ? 32'hFFFF_FFFF : 32'd64);
    if (near_wrap && (32'hFFFF_FF80 - arm_ms) >= win_ms) t0 = 32'hFFFF_FF80;
    push_item(CMD_RECORD, t0, $urandom, {$urandom, $urandom}, 1'b0);
    push_item(CMD_STATUS, t0, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
    push_item(CMD_ARM, t0, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
    tn = t0;
    stepmax = win_ms / (n_rec + 1);
    for (i = 0; i < n_rec; i++) begin
      tn = tn + $urandom_range(stepmax, 0);
      case ($urandom_range(9))
        0: smp = past_window(t0, 32'hFFFF_FFFF);
        1: smp = $urandom;
        default: smp = (win_ms > 1) ? t0 + ($urandom % win_ms) : t0;
      endcase
      push_item(CMD_RECORD, tn, smp, {$urandom, $urandom}, $urandom_range(11) == 0);
      if ($urandom_range(5) == 0)
        push_item(3'($urandom_range(7)), tn, $urandom, {$urandom, $urandom},
                  1'($urandom_range(1)));
    end
    tn = past_window(t0, 32'd500);
    push_item(CMD_RECORD, tn, $urandom, {$urandom, $urandom}, 1'b0);
    push_item(CMD_DUMP, $urandom, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
    for (i = 0; i < n_rec + 2; i++) begin
      if ($urandom_range(19) == 0)
        push_item($urandom_range(1) ? CMD_STATUS : CMD_DUMP, $urandom, $urandom,
                  {$urandom, $urandom}, 1'($urandom_range(1)));
      push_item(CMD_NEXT, $urandom, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    int s;
    logic [31:0] w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;
    tx_idle_pct = 10;
    rx_idle_pct = 55;
    directed();
    for (s = 0; s < 12; s++) begin
      if (s == 4) begin
        tx_idle_pct = 55;
        rx_idle_pct = 10;
      end
      if (s == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (s)
        0, 7:    w = 32'd1;
        1:       w = $urandom_range(5000, 20);
        2, 10:   w = 32'hFFFF_FFFF;
        3:       w = WINDOW_RESET;
        4:       w = 32'd0;
        6:       w = $urandom_range(100, 2);
        8:       w = 32'hFFFF_FFFE;
        9:       w = $urandom_range(20000, 100);
        default: w = $urandom | 32'd1;
      endcase
      set_window(w);
      run_session($urandom_range(30, 6), s == 3 || s == 9);
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tcb_pkg.sv
rtl/core/tcb_ram.sv
rtl/core/tcb_hash.sv
rtl/core/windowed_trace_capture_buffer.sv
test/tb.sv
